[sv/bdu_pkg.sv]
`default_nettype none

package bdu_pkg;

    // Internal word: holds any carried field, day count or year with margin.
    localparam int W      = 48;
    localparam int DEN_W  = 18;
    localparam int ACC_W  = 64;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SEC, ST_MIN, ST_HR, ST_MON, ST_Y, ST_EYR, ST_DOE1, ST_ERA1,
        ST_DAYS1, ST_DAYS2, ST_Z, ST_DA, ST_DB, ST_DC, ST_NUM, ST_DD, ST_DOY,
        ST_DE, ST_FIN, ST_WD, ST_MLO, ST_MHI, ST_HMS, ST_OUT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_IN, OP_SEC, OP_MIN, OP_HR, OP_MON, OP_Y, OP_EYR, OP_DOE1,
        OP_ERA1, OP_DAYS1, OP_DAYS2, OP_Z, OP_DA, OP_DB, OP_DC, OP_NUM, OP_DD,
        OP_DOY, OP_DE, OP_FIN, OP_WD, OP_MLO, OP_MHI, OP_HMS
    } op_t;

    typedef struct packed {
        op_t  op;
        logic start;
        logic load;
    } cmd_t;

endpackage

`default_nettype wire

[sv/bdu_div.sv]
`default_nettype none

module bdu_div
    import bdu_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic signed [W-1:0]     dividend,
    input  wire logic [DEN_W-1:0]        divisor,
    output logic                         done,
    output logic signed [W-1:0]          quotient,
    output logic [DEN_W-1:0]             remainder
);

    // long division in 12-bit digits: each digit is estimated from the
    // reciprocal of the divisor, then fixed by one compare and subtract
    localparam int DIG_W  = 12;
    localparam int N_DIG  = W / DIG_W;
    localparam int X_W    = DEN_W + DIG_W;
    localparam int RCP_W  = X_W + 1;
    localparam int PROD_W = X_W + RCP_W;
    localparam int CNT_W  = $clog2(N_DIG);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(N_DIG - 1);
    localparam longint ONE = longint'(1) << X_W;

    function automatic logic [RCP_W-1:0] recip(input logic [DEN_W-1:0] d);
        case (d)
            DEN_W'(7):      return RCP_W'(ONE / 7);
            DEN_W'(12):     return RCP_W'(ONE / 12);
            DEN_W'(24):     return RCP_W'(ONE / 24);
            DEN_W'(60):     return RCP_W'(ONE / 60);
            DEN_W'(153):    return RCP_W'(ONE / 153);
            DEN_W'(365):    return RCP_W'(ONE / 365);
            DEN_W'(400):    return RCP_W'(ONE / 400);
            DEN_W'(1460):   return RCP_W'(ONE / 1460);
            DEN_W'(36524):  return RCP_W'(ONE / 36524);
            DEN_W'(146096): return RCP_W'(ONE / 146096);
            DEN_W'(146097): return RCP_W'(ONE / 146097);
            default:        return RCP_W'(ONE);
        endcase
    endfunction

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                phase_reg, phase_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [W-1:0]        num_reg, num_next;
    logic [W-1:0]        quo_reg, quo_next;
    logic [DEN_W-1:0]    rem_reg, rem_next;
    logic [DEN_W-1:0]    den_reg, den_next;
    logic [RCP_W-1:0]    rcp_reg, rcp_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic                neg_reg, neg_next;
    logic [X_W-1:0]      part;
    logic [DIG_W-1:0]    q_est;
    logic [X_W-1:0]      r_est;
    logic                ge;

    assign part  = {rem_reg, num_reg[W-1 -: DIG_W]};
    assign q_est = prod_reg[X_W +: DIG_W];
    assign r_est = part - X_W'(q_est) * X_W'(den_reg);
    assign ge    = r_est >= X_W'(den_reg);

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        num_next   = num_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        rcp_next   = rcp_reg;
        prod_next  = prod_reg;
        neg_next   = neg_reg;
        if (start) begin
            // floor division: a negative a maps to ~a = -a-1
            neg_next   = dividend[W-1];
            num_next   = dividend[W-1] ? ~dividend : dividend;
            quo_next   = '0;
            rem_next   = '0;
            den_next   = divisor;
            rcp_next   = recip(divisor);
            cnt_next   = '0;
            phase_next = 1'b0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            if (!phase_reg) begin
                prod_next  = PROD_W'(part) * PROD_W'(rcp_reg);
                phase_next = 1'b1;
            end else begin
                // the estimate is low by at most one
                quo_next   = {quo_reg[W-DIG_W-1:0], ge ? DIG_W'(q_est + 1'b1) : q_est};
                rem_next   = DEN_W'(ge ? r_est - X_W'(den_reg) : r_est);
                num_next   = {num_reg[W-DIG_W-1:0], DIG_W'(0)};
                cnt_next   = cnt_reg + 1'b1;
                phase_next = 1'b0;
                if (cnt_reg == LAST) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        phase_reg <= phase_next;
        cnt_reg   <= cnt_next;
        num_reg   <= num_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        rcp_reg   <= rcp_next;
        prod_reg  <= prod_next;
        neg_reg   <= neg_next;
    end

    assign done      = done_reg;
    assign quotient  = neg_reg ? signed'(~quo_reg) : signed'(quo_reg);
    assign remainder = neg_reg ? DEN_W'(den_reg - 1'b1 - rem_reg) : rem_reg;

endmodule

`default_nettype wire

[sv/bdu_ctrl.sv]
`default_nettype none

module bdu_ctrl
    import bdu_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    input  wire logic div_done,
    output cmd_t      cmd
);

    state_t state_reg, state_next;
    logic   launched_reg, launched_next;
    logic   is_div;
    logic   step;

    always_comb begin
        case (state_reg)
            ST_SEC, ST_MIN, ST_HR, ST_MON, ST_EYR, ST_Z, ST_DA, ST_DB, ST_DC,
            ST_DD, ST_DE, ST_WD: is_div = 1'b1;
            default:             is_div = 1'b0;
        endcase
    end

    // a divide state advances when its quotient lands; other compute states advance every cycle
    assign step = is_div ? (launched_reg && div_done) : 1'b1;

    always_comb begin
        state_next    = state_reg;
        launched_next = launched_reg;
        if (is_div) begin
            if (!launched_reg) launched_next = 1'b1;
            else if (div_done) launched_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_SEC;
            ST_SEC:   if (step) state_next = ST_MIN;
            ST_MIN:   if (step) state_next = ST_HR;
            ST_HR:    if (step) state_next = ST_MON;
            ST_MON:   if (step) state_next = ST_Y;
            ST_Y:     state_next = ST_EYR;
            ST_EYR:   if (step) state_next = ST_DOE1;
            ST_DOE1:  state_next = ST_ERA1;
            ST_ERA1:  state_next = ST_DAYS1;
            ST_DAYS1: state_next = ST_DAYS2;
            ST_DAYS2: state_next = ST_Z;
            ST_Z:     if (step) state_next = ST_DA;
            ST_DA:    if (step) state_next = ST_DB;
            ST_DB:    if (step) state_next = ST_DC;
            ST_DC:    if (step) state_next = ST_NUM;
            ST_NUM:   state_next = ST_DD;
            ST_DD:    if (step) state_next = ST_DOY;
            ST_DOY:   state_next = ST_DE;
            ST_DE:    if (step) state_next = ST_FIN;
            ST_FIN:   state_next = ST_WD;
            ST_WD:    if (step) state_next = ST_MLO;
            ST_MLO:   state_next = ST_MHI;
            ST_MHI:   state_next = ST_HMS;
            ST_HMS:   state_next = ST_OUT;
            ST_OUT:   if (m_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        m_valid   = 1'b0;
        cmd.start = is_div && !launched_reg;
        cmd.load  = step;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.op   = OP_IN;
                cmd.load = s_valid;
            end
            ST_SEC:   cmd.op = OP_SEC;
            ST_MIN:   cmd.op = OP_MIN;
            ST_HR:    cmd.op = OP_HR;
            ST_MON:   cmd.op = OP_MON;
            ST_Y:     cmd.op = OP_Y;
            ST_EYR:   cmd.op = OP_EYR;
            ST_DOE1:  cmd.op = OP_DOE1;
            ST_ERA1:  cmd.op = OP_ERA1;
            ST_DAYS1: cmd.op = OP_DAYS1;
            ST_DAYS2: cmd.op = OP_DAYS2;
            ST_Z:     cmd.op = OP_Z;
            ST_DA:    cmd.op = OP_DA;
            ST_DB:    cmd.op = OP_DB;
            ST_DC:    cmd.op = OP_DC;
            ST_NUM:   cmd.op = OP_NUM;
            ST_DD:    cmd.op = OP_DD;
            ST_DOY:   cmd.op = OP_DOY;
            ST_DE:    cmd.op = OP_DE;
            ST_FIN:   cmd.op = OP_FIN;
            ST_WD:    cmd.op = OP_WD;
            ST_MLO:   cmd.op = OP_MLO;
            ST_MHI:   cmd.op = OP_MHI;
            ST_HMS:   cmd.op = OP_HMS;
            ST_OUT: begin
                m_valid  = 1'b1;
                cmd.op   = OP_NONE;
                cmd.load = 1'b0;
            end
            default: begin
                cmd.op   = OP_NONE;
                cmd.load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            launched_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
        end
    end

endmodule

`default_nettype wire

[sv/bdu_dp.sv]
`default_nettype none

module bdu_dp
    import bdu_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cmd_t               cmd,
    output logic                    div_done,
    input  wire logic signed [31:0] s_second,
    input  wire logic signed [31:0] s_minute,
    input  wire logic signed [31:0] s_hour,
    input  wire logic signed [31:0] s_day_of_month,
    input  wire logic signed [31:0] s_month,
    input  wire logic signed [31:0] s_years_since_1900,
    output logic signed [63:0]      m_epoch_seconds,
    output logic [5:0]              m_norm_second,
    output logic [5:0]              m_norm_minute,
    output logic [4:0]              m_norm_hour,
    output logic [4:0]              m_norm_day,
    output logic [3:0]              m_norm_month,
    output logic signed [31:0]      m_norm_years_since_1900,
    output logic [8:0]              m_day_of_year,
    output logic [2:0]              m_weekday,
    output logic                    m_overflow
);

    function automatic logic [W-1:0] sx32(input logic [31:0] v);
        return {{(W-32){v[31]}}, v};
    endfunction

    function automatic logic fits32(input logic [W-1:0] v);
        return (&v[W-1:31]) | ~(|v[W-1:31]);
    endfunction

    function automatic logic [1:0] div100(input logic [8:0] y);
        return (y >= 9'd300) ? 2'd3 : (y >= 9'd200) ? 2'd2 : (y >= 9'd100) ? 2'd1 : 2'd0;
    endfunction

    // day offset of the first of a March-based month
    function automatic logic [8:0] mar_ofs(input logic [3:0] mp);
        case (mp)
            4'd0:    return 9'd0;
            4'd1:    return 9'd31;
            4'd2:    return 9'd61;
            4'd3:    return 9'd92;
            4'd4:    return 9'd122;
            4'd5:    return 9'd153;
            4'd6:    return 9'd184;
            4'd7:    return 9'd214;
            4'd8:    return 9'd245;
            4'd9:    return 9'd275;
            4'd10:   return 9'd306;
            4'd11:   return 9'd337;
            default: return 9'd0;
        endcase
    endfunction

    // January-based month to March-based month
    function automatic logic [3:0] jan_to_mar(input logic [3:0] m);
        return (m >= 4'd2) ? 4'(m - 4'd2) : 4'(m + 4'd10);
    endfunction

    logic signed [W-1:0] sec_reg, min_reg, hr_reg, mday_reg, mon_reg, yr_reg, y_reg;
    logic signed [W-1:0] era_reg, days_reg;
    logic [8:0]          yoe_reg, doy_reg, yday_reg;
    logic [17:0]         doe_reg, num_reg;
    logic [6:0]          t1_reg;
    logic [2:0]          t2_reg, wday_reg;
    logic                t3_reg, ovf_reg;
    logic [3:0]          mp_reg, nmon_reg;
    logic [4:0]          nday_reg;
    logic [31:0]         nyear_reg;
    logic [ACC_W-1:0]    acc_reg;

    logic                div_start;
    logic signed [W-1:0] div_a, div_q;
    logic [DEN_W-1:0]    div_d, div_r;

    logic [17:0]         yoe365, yoe_days;
    logic signed [43:0]  era_days;
    logic signed [34:0]  era_years;
    logic signed [W-1:0] full_year, norm_year;
    logic [40:0]         lo_prod;
    logic signed [41:0]  hi_prod;
    logic [16:0]         hms;

    assign div_start = cmd.start;

    always_comb begin
        case (cmd.op)
            OP_SEC:  begin div_a = sec_reg;  div_d = 18'd60;     end
            OP_MIN:  begin div_a = min_reg;  div_d = 18'd60;     end
            OP_HR:   begin div_a = hr_reg;   div_d = 18'd24;     end
            OP_MON:  begin div_a = mon_reg;  div_d = 18'd12;     end
            OP_EYR:  begin div_a = y_reg;    div_d = 18'd400;    end
            OP_Z:    begin div_a = days_reg + W'(719468); div_d = 18'd146097; end
            OP_DA:   begin div_a = W'(doe_reg); div_d = 18'd1460;   end
            OP_DB:   begin div_a = W'(doe_reg); div_d = 18'd36524;  end
            OP_DC:   begin div_a = W'(doe_reg); div_d = 18'd146096; end
            OP_DD:   begin div_a = W'(num_reg); div_d = 18'd365;    end
            OP_DE:   begin div_a = W'(12'(doy_reg) * 12'd5 + 12'd2); div_d = 18'd153; end
            OP_WD:   begin div_a = days_reg + W'(4); div_d = 18'd7;  end
            default: begin div_a = '0; div_d = 18'd1; end
        endcase
    end

    bdu_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_d),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign yoe365    = 18'(yoe_reg) * 18'd365;
    assign yoe_days  = yoe365 + 18'(yoe_reg >> 2) - 18'(div100(yoe_reg));
    assign era_days  = $signed(era_reg[24:0]) * $signed(19'sd146097);
    assign era_years = $signed(era_reg[24:0]) * $signed(10'sd400);
    assign full_year = W'(yoe_reg) + W'(era_years) + W'(mp_reg >= 4'd10);
    assign norm_year = full_year - W'(1900);
    assign lo_prod   = days_reg[23:0] * 17'd86400;
    assign hi_prod   = $signed(days_reg[W-1:24]) * $signed(18'sd86400);
    assign hms       = 17'(hr_reg[4:0]) * 17'd3600 + 17'(min_reg[5:0]) * 17'd60
                       + 17'(sec_reg[5:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovf_reg <= 1'b0;
        end else if (cmd.load) begin
            case (cmd.op)
                OP_IN:   ovf_reg <= 1'b0;
                OP_SEC:  ovf_reg <= ovf_reg | ~fits32(min_reg + div_q);
                OP_MIN:  ovf_reg <= ovf_reg | ~fits32(hr_reg + div_q);
                OP_HR:   ovf_reg <= ovf_reg | ~fits32(mday_reg + div_q);
                OP_MON:  ovf_reg <= ovf_reg | ~fits32(yr_reg + div_q);
                OP_FIN:  ovf_reg <= ovf_reg | ~fits32(norm_year);
                default: ovf_reg <= ovf_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            case (cmd.op)
                OP_IN: begin
                    sec_reg  <= sx32(s_second);
                    min_reg  <= sx32(s_minute);
                    hr_reg   <= sx32(s_hour);
                    mday_reg <= sx32(s_day_of_month);
                    mon_reg  <= sx32(s_month);
                    yr_reg   <= sx32(s_years_since_1900);
                end
                OP_SEC: begin
                    min_reg <= min_reg + div_q;
                    sec_reg <= W'(div_r);
                end
                OP_MIN: begin
                    hr_reg  <= hr_reg + div_q;
                    min_reg <= W'(div_r);
                end
                OP_HR: begin
                    mday_reg <= mday_reg + div_q;
                    hr_reg   <= W'(div_r);
                end
                OP_MON: begin
                    yr_reg  <= yr_reg + div_q;
                    mon_reg <= W'(div_r);
                end
                // January and February count with the year before
                OP_Y:    y_reg <= yr_reg + W'(1900) - W'(mon_reg[3:0] <= 4'd1);
                OP_EYR: begin
                    era_reg <= div_q;
                    yoe_reg <= div_r[8:0];
                end
                OP_DOE1: doe_reg <= yoe_days + 18'(mar_ofs(jan_to_mar(mon_reg[3:0])));
                OP_ERA1: days_reg <= W'(era_days);
                OP_DAYS1: days_reg <= days_reg + W'(doe_reg);
                OP_DAYS2: days_reg <= days_reg + mday_reg - W'(719469);
                OP_Z: begin
                    era_reg <= div_q;
                    doe_reg <= div_r;
                end
                OP_DA:  t1_reg <= div_q[6:0];
                OP_DB:  t2_reg <= div_q[2:0];
                OP_DC:  t3_reg <= div_q[0];
                OP_NUM: num_reg <= doe_reg - 18'(t1_reg) + 18'(t2_reg) - 18'(t3_reg);
                OP_DD:  yoe_reg <= div_q[8:0];
                OP_DOY: doy_reg <= 9'(doe_reg - yoe_days);
                OP_DE:  mp_reg <= div_q[3:0];
                OP_FIN: begin
                    nday_reg  <= 5'(doy_reg - mar_ofs(mp_reg) + 9'd1);
                    nmon_reg  <= (mp_reg < 4'd10) ? 4'(mp_reg + 4'd2) : 4'(mp_reg - 4'd10);
                    nyear_reg <= norm_year[31:0];
                    if (mp_reg >= 4'd10) begin
                        yday_reg <= 9'(doy_reg - 9'd306);
                    end else if (yoe_reg[1:0] == 2'd0 && yoe_reg != 9'd100 &&
                                 yoe_reg != 9'd200 && yoe_reg != 9'd300) begin
                        yday_reg <= 9'(doy_reg + 9'd60);
                    end else begin
                        yday_reg <= 9'(doy_reg + 9'd59);
                    end
                end
                OP_WD:  wday_reg <= div_r[2:0];
                OP_MLO: acc_reg <= ACC_W'(lo_prod);
                OP_MHI: acc_reg <= acc_reg + (ACC_W'(hi_prod) << 24);
                OP_HMS: acc_reg <= acc_reg + ACC_W'(hms);
                default: ;
            endcase
        end
    end

    assign m_overflow              = ovf_reg;
    assign m_epoch_seconds         = ovf_reg ? '1 : signed'(acc_reg);
    assign m_norm_second           = ovf_reg ? '0 : sec_reg[5:0];
    assign m_norm_minute           = ovf_reg ? '0 : min_reg[5:0];
    assign m_norm_hour             = ovf_reg ? '0 : hr_reg[4:0];
    assign m_norm_day              = ovf_reg ? '0 : nday_reg;
    assign m_norm_month            = ovf_reg ? '0 : nmon_reg;
    assign m_norm_years_since_1900 = ovf_reg ? '0 : signed'(nyear_reg);
    assign m_day_of_year           = ovf_reg ? '0 : yday_reg;
    assign m_weekday               = ovf_reg ? '0 : wday_reg;

endmodule

`default_nettype wire

[sv/broken_down_utc_to_epoch_seconds.sv]
// Broken-down UTC time to seconds since 1970.
// Input channel s_*: second, minute, hour, day of month, month (0 = January)
// and years since 1900, each signed 32 bits, any value. Fields carry upward
// with floor semantics and the day rolls across months under Gregorian rules.
// Result channel m_*: epoch seconds, the normalized fields, day of year,
// weekday (0 = Sunday) and an overflow flag. On overflow the seconds read -1
// and every field but the flag reads zero.
// One item is in flight at a time. A shared divider works each quotient as
// four 12-bit digits, each from a reciprocal estimate and one correction.
// Twelve floor divisions by constants and eleven further steps lead to
// m_valid; s_ready returns the cycle after the result is taken.
// Synchronous active-low reset returns the controller to idle with s_ready
// high and m_valid low. While m_ready is low the result is held unchanged
// and no new item is accepted.
`default_nettype none

module broken_down_utc_to_epoch_seconds
    import bdu_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_second,
    input  wire logic signed [31:0] s_minute,
    input  wire logic signed [31:0] s_hour,
    input  wire logic signed [31:0] s_day_of_month,
    input  wire logic signed [31:0] s_month,
    input  wire logic signed [31:0] s_years_since_1900,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [63:0]      m_epoch_seconds,
    output logic [5:0]              m_norm_second,
    output logic [5:0]              m_norm_minute,
    output logic [4:0]              m_norm_hour,
    output logic [4:0]              m_norm_day,
    output logic [3:0]              m_norm_month,
    output logic signed [31:0]      m_norm_years_since_1900,
    output logic [8:0]              m_day_of_year,
    output logic [2:0]              m_weekday,
    output logic                    m_overflow
);

    cmd_t cmd;
    logic div_done;

    bdu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .div_done (div_done),
        .cmd      (cmd)
    );

    bdu_dp u_dp (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .cmd                     (cmd),
        .div_done                (div_done),
        .s_second                (s_second),
        .s_minute                (s_minute),
        .s_hour                  (s_hour),
        .s_day_of_month          (s_day_of_month),
        .s_month                 (s_month),
        .s_years_since_1900      (s_years_since_1900),
        .m_epoch_seconds         (m_epoch_seconds),
        .m_norm_second           (m_norm_second),
        .m_norm_minute           (m_norm_minute),
        .m_norm_hour             (m_norm_hour),
        .m_norm_day              (m_norm_day),
        .m_norm_month            (m_norm_month),
        .m_norm_years_since_1900 (m_norm_years_since_1900),
        .m_day_of_year           (m_day_of_year),
        .m_weekday               (m_weekday),
        .m_overflow              (m_overflow)
    );

endmodule

`default_nettype wire

[sv/bdu_checker.sv]
`default_nettype none

module bdu_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [63:0] m_epoch_seconds,
    input wire logic [5:0]         m_norm_second,
    input wire logic [5:0]         m_norm_minute,
    input wire logic [4:0]         m_norm_hour,
    input wire logic [3:0]         m_norm_month,
    input wire logic [2:0]         m_weekday,
    input wire logic               m_overflow
);

    // overflow results carry all-ones seconds
    a_ovf_seconds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> m_epoch_seconds == -64'sd1)
        else $error("overflow item without -1 seconds");

    a_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_overflow |-> m_norm_second < 6'd60 && m_norm_minute < 6'd60 &&
            m_norm_hour < 5'd24 && m_norm_month < 4'd12 && m_weekday < 3'd7)
        else $error("normalized field out of range");

    // one item in flight: an accepted item never shows a result next cycle
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid && !s_ready)
        else $error("result or new accept right after accept");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_epoch_seconds))
        else $error("stalled result changed");

endmodule

bind broken_down_utc_to_epoch_seconds bdu_checker u_bdu_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_epoch_seconds (m_epoch_seconds),
    .m_norm_second   (m_norm_second),
    .m_norm_minute   (m_norm_minute),
    .m_norm_hour     (m_norm_hour),
    .m_norm_month    (m_norm_month),
    .m_weekday       (m_weekday),
    .m_overflow      (m_overflow)
);

`default_nettype wire

[bench/tb.sv]
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint I32_MIN = -64'sd2147483648;
    localparam longint I32_MAX = 64'sd2147483647;
    localparam int     N_RANDOM = 1030;
    localparam longint CYCLE_LIMIT = 3_000_000;
    localparam int     LONG_HOLD = 3000;

    typedef struct {
        logic signed [31:0] sec;
        logic signed [31:0] min;
        logic signed [31:0] hr;
        logic signed [31:0] mday;
        logic signed [31:0] mon;
        logic signed [31:0] yr;
    } utc_fields_t;

    typedef struct {
        logic signed [63:0] epoch;
        logic [5:0]         sec;
        logic [5:0]         min;
        logic [4:0]         hr;
        logic [4:0]         day;
        logic [3:0]         mon;
        logic signed [31:0] yr;
        logic [8:0]         yday;
        logic [2:0]         wday;
        logic               ovf;
    } epoch_result_t;

    typedef struct {
        utc_fields_t   f;
        bit            typed;
        epoch_result_t r;
    } directed_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    wire logic           s_ready;
    logic signed [31:0]  s_second;
    logic signed [31:0]  s_minute;
    logic signed [31:0]  s_hour;
    logic signed [31:0]  s_day_of_month;
    logic signed [31:0]  s_month;
    logic signed [31:0]  s_years_since_1900;
    wire logic           m_valid;
    logic                m_ready;
    wire logic signed [63:0] m_epoch_seconds;
    wire logic [5:0]     m_norm_second;
    wire logic [5:0]     m_norm_minute;
    wire logic [4:0]     m_norm_hour;
    wire logic [4:0]     m_norm_day;
    wire logic [3:0]     m_norm_month;
    wire logic signed [31:0] m_norm_years_since_1900;
    wire logic [8:0]     m_day_of_year;
    wire logic [2:0]     m_weekday;
    wire logic           m_overflow;

    epoch_result_t pending_results[$];
    int            mismatches = 0;
    int            items_sent = 0;
    int            results_seen = 0;
    int            overflow_seen = 0;
    bit            hold_output = 0;
    longint        cycles = 0;

    broken_down_utc_to_epoch_seconds dut (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout at %0t after %0d cycles", $time, cycles);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if (a % b < 0) q--;
        return q;
    endfunction

    function automatic bit fits_i32(longint v);
        return v >= I32_MIN && v <= I32_MAX;
    endfunction

    // days from 1970-01-01 to year y, month m (1..12), day d
    function automatic longint civil_to_days(longint y, longint m, longint d);
        longint era, yoe, mp, doy, doe;
        if (m <= 2) y--;
        era = floor_div(y, 400);
        yoe = y - era * 400;
        mp  = (m + 9) % 12;
        doy = (153 * mp + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    function automatic void days_to_civil(longint z, output longint y, output longint m,
                                          output longint d);
        longint era, doe, yoe, doy, mp;
        z += 719468;
        era = floor_div(z, 146097);
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        d   = doy - (153 * mp + 2) / 5 + 1;
        m   = mp < 10 ? mp + 3 : mp - 9;
        y   = yoe + era * 400 + (m <= 2 ? 1 : 0);
    endfunction

    function automatic epoch_result_t predict_epoch(utc_fields_t f);
        longint sec, min, hr, mday, mon, yr, q, days, fy, fm, fd, ny;
        bit ok;
        epoch_result_t r;
        sec = longint'(f.sec); min = longint'(f.min); hr = longint'(f.hr);
        mday = longint'(f.mday); mon = longint'(f.mon); yr = longint'(f.yr);
        ok = 1;
        q = floor_div(sec, 60); min += q; sec -= q * 60;
        ok = fits_i32(min);
        if (ok) begin q = floor_div(min, 60); hr += q; min -= q * 60; ok = fits_i32(hr); end
        if (ok) begin q = floor_div(hr, 24); mday += q; hr -= q * 24; ok = fits_i32(mday); end
        if (ok) begin q = floor_div(mon, 12); yr += q; mon -= q * 12; ok = fits_i32(yr); end
        if (ok) begin
            days = civil_to_days(yr + 1900, mon + 1, 1) + mday - 1;
            days_to_civil(days, fy, fm, fd);
            ny = fy - 1900;
            ok = fits_i32(ny);
        end
        if (!ok) begin
            r = '{epoch: -64'sd1, ovf: 1'b1, default: '0};
            return r;
        end
        r.epoch = days * 86400 + hr * 3600 + min * 60 + sec;
        r.sec   = sec[5:0];
        r.min   = min[5:0];
        r.hr    = hr[4:0];
        r.day   = fd[4:0];
        r.mon   = 4'(fm - 1);
        r.yr    = ny[31:0];
        r.yday  = 9'(days - civil_to_days(fy, 1, 1));
        r.wday  = 3'(days + 4 - floor_div(days + 4, 7) * 7);
        r.ovf   = 1'b0;
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    function automatic logic signed [31:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh0000_0000;
            3: return -32'sd1;
            4: return 32'sh8000_0001;
            default: return 32'sh7fff_fffe;
        endcase
    endfunction

    // mostly plausible dates, some loose carries, some raw noise, some extremes
    function automatic utc_fields_t random_fields();
        utc_fields_t f;
        int p;
        p = $urandom_range(0, 99);
        f.sec  = $urandom_range(0, 59);
        f.min  = $urandom_range(0, 59);
        f.hr   = $urandom_range(0, 23);
        f.mday = $urandom_range(1, 31);
        f.mon  = $urandom_range(0, 11);
        f.yr   = $signed($urandom_range(0, 600)) - 300;
        if (p >= 55 && p < 80) begin
            f.sec  = $signed($urandom_range(0, 20000)) - 10000;
            f.min  = $signed($urandom_range(0, 20000)) - 10000;
            f.hr   = $signed($urandom_range(0, 2000)) - 1000;
            f.mday = $signed($urandom_range(0, 4000)) - 2000;
            f.mon  = $signed($urandom_range(0, 400)) - 200;
        end else if (p >= 80 && p < 92) begin
            f = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end else if (p >= 92) begin
            if ($urandom_range(0, 1)) f.sec = pick_extreme();
            if ($urandom_range(0, 1)) f.min = pick_extreme();
            if ($urandom_range(0, 1)) f.hr = pick_extreme();
            if ($urandom_range(0, 1)) f.mday = pick_extreme();
            if ($urandom_range(0, 1)) f.mon = pick_extreme();
            if ($urandom_range(0, 1)) f.yr = pick_extreme();
        end
        return f;
    endfunction

    task automatic send_item(utc_fields_t f, epoch_result_t r, int gap);
        s_valid            <= 1'b1;
        s_second           <= f.sec;
        s_minute           <= f.min;
        s_hour             <= f.hr;
        s_day_of_month     <= f.mday;
        s_month            <= f.mon;
        s_years_since_1900 <= f.yr;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(r);
        items_sent++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // check results and randomize m_ready
    initial begin
        epoch_result_t e;
        int stall;
        m_ready = 0;
        stall = 0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected item, epoch %0d", $time, m_epoch_seconds);
                    mismatches++;
                end else begin
                    e = pending_results.pop_front();
                    if (m_overflow) overflow_seen++;
                    if (m_epoch_seconds !== e.epoch || m_norm_second !== e.sec ||
                        m_norm_minute !== e.min || m_norm_hour !== e.hr ||
                        m_norm_day !== e.day || m_norm_month !== e.mon ||
                        m_norm_years_since_1900 !== e.yr || m_day_of_year !== e.yday ||
                        m_weekday !== e.wday || m_overflow !== e.ovf) begin
                        mismatches++;
                        $display("%0t: mismatch expected epoch=%0d s=%0d m=%0d h=%0d d=%0d mo=%0d y=%0d yd=%0d wd=%0d ovf=%0b",
                                 $time, e.epoch, e.sec, e.min, e.hr, e.day, e.mon, e.yr,
                                 e.yday, e.wday, e.ovf);
                        $display("%0t:          actual   epoch=%0d s=%0d m=%0d h=%0d d=%0d mo=%0d y=%0d yd=%0d wd=%0d ovf=%0b",
                                 $time, m_epoch_seconds, m_norm_second, m_norm_minute,
                                 m_norm_hour, m_norm_day, m_norm_month,
                                 m_norm_years_since_1900, m_day_of_year, m_weekday, m_overflow);
                    end
                end
            end
            if (hold_output) begin
                hold_output = 0;
                stall = LONG_HOLD;
            end
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < 30) begin
                stall = pick_gap();
                m_ready <= (stall == 0);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        directed_row_t rows[$];
        epoch_result_t r;
        utc_fields_t f;
        int settle;
        aresetn = 0;
        s_valid = 0;
        {s_second, s_minute, s_hour, s_day_of_month, s_month, s_years_since_1900} = '0;

        rows.push_back('{'{0, 0, 0, 1, 0, 70}, 1,
                         '{0, 0, 0, 0, 1, 0, 70, 0, 4, 0}});
        rows.push_back('{'{-1, 0, 0, 1, 0, 70}, 1,
                         '{-1, 59, 59, 23, 31, 11, 69, 364, 3, 0}});
        rows.push_back('{'{0, 0, 0, 1, 0, 0}, 1,
                         '{-64'sd2208988800, 0, 0, 0, 1, 0, 0, 0, 1, 0}});
        // year carry leaves 32 bits
        rows.push_back('{'{0, 0, 0, 1, 12, 32'sh7fff_ffff}, 1,
                         '{-1, 0, 0, 0, 0, 0, 0, 0, 0, 1}});
        rows.push_back('{'{0, 0, 0, 1, -1, 32'sh8000_0000}, 1,
                         '{-1, 0, 0, 0, 0, 0, 0, 0, 0, 1}});
        // minute carry leaves 32 bits
        rows.push_back('{'{60, 32'sh7fff_ffff, 0, 1, 0, 70}, 1,
                         '{-1, 0, 0, 0, 0, 0, 0, 0, 0, 1}});
        rows.push_back('{'{-1, 32'sh8000_0000, 0, 1, 0, 70}, 1,
                         '{-1, 0, 0, 0, 0, 0, 0, 0, 0, 1}});
        // hour and day carries leave 32 bits
        rows.push_back('{'{0, 60, 32'sh7fff_ffff, 1, 0, 70}, 1,
                         '{-1, 0, 0, 0, 0, 0, 0, 0, 0, 1}});
        rows.push_back('{'{0, 0, 24, 32'sh7fff_ffff, 0, 70}, 1,
                         '{-1, 0, 0, 0, 0, 0, 0, 0, 0, 1}});
        rows.push_back('{'{0, 0, -1, 32'sh8000_0000, 0, 70}, 1,
                         '{-1, 0, 0, 0, 0, 0, 0, 0, 0, 1}});
        // rolled year leaves 32 bits
        rows.push_back('{'{0, 0, 0, 32, 11, 32'sh7fff_ffff}, 1,
                         '{-1, 0, 0, 0, 0, 0, 0, 0, 0, 1}});
        rows.push_back('{'{0, 0, 0, 0, 0, 32'sh8000_0000}, 1,
                         '{-1, 0, 0, 0, 0, 0, 0, 0, 0, 1}});
        rows.push_back('{'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                           32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}, 0, '{default: '0}});
        rows.push_back('{'{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                           32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff}, 0, '{default: '0}});
        rows.push_back('{'{32'sh7fff_ffff, 0, 0, 1, 0, 70}, 0, '{default: '0}});
        rows.push_back('{'{0, 0, 0, 32'sh7fff_ffff, 0, 0}, 0, '{default: '0}});
        rows.push_back('{'{0, 0, 0, 32'sh8000_0000, 0, 0}, 0, '{default: '0}});
        rows.push_back('{'{59, 59, 23, 29, 1, 100}, 0, '{default: '0}});
        rows.push_back('{'{0, 0, 0, 29, 1, 0}, 0, '{default: '0}});
        rows.push_back('{'{0, 0, 0, 31, 11, 104}, 0, '{default: '0}});
        rows.push_back('{'{0, 0, 0, 1, 32'sh7fff_ffff, 32'sh8000_0000}, 0, '{default: '0}});
        rows.push_back('{'{0, 0, 0, 1, 32'sh8000_0000, 32'sh7fff_ffff}, 0, '{default: '0}});
        rows.push_back('{'{0, 0, 0, 1, 11, 32'sh7fff_ffff}, 0, '{default: '0}});

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) begin
            r = rows[i].typed ? rows[i].r : predict_epoch(rows[i].f);
            send_item(rows[i].f, r, pick_gap());
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 200) hold_output = 1;
            if (n == 500) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (pending_results.size() != 0);
            end
            f = random_fields();
            send_item(f, predict_epoch(f), (n % 64 < 16) ? 0 : pick_gap());
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        settle = 0;
        while (settle < 50) begin
            @(posedge aclk);
            settle++;
        end
        $display("Sent %0d items (directed extremes, carry overflows, leap days, random dates);",
                 items_sent);
        $display("checked %0d results, %0d of them overflow, %0d mismatches.",
                 results_seen, overflow_seen, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
sv/bdu_pkg.sv
sv/bdu_div.sv
sv/bdu_ctrl.sv
sv/bdu_dp.sv
sv/broken_down_utc_to_epoch_seconds.sv
sv/bdu_checker.sv
bench/tb.sv
